// File: rtl/core/mcd_pkg.sv
// Shared types and constants for the multi-click detector.
// No dependencies; used by mcd_in_if, mcd_history and the top level.
package mcd_pkg;

  typedef enum logic {
    OP_PRESS   = 1'b0,
    OP_RELEASE = 1'b1
  } mcd_op_t;

  localparam logic [15:0] CFG_INTERVAL_RESET = 16'd250;
  localparam logic [2:0]  BUTTON_MAX         = 3'd3;
  localparam logic [1:0]  RELEASE_SAT        = 2'd3;
  localparam logic [1:0]  RELEASE_DOUBLE_MIN = 2'd2;
  localparam logic [1:0]  RELEASE_TRIPLE_MIN = 2'd3;

  // One input event as seen at the accepting edge.
  typedef struct packed {
    mcd_op_t     op;
    logic [31:0] timestamp;
    logic [15:0] window_id;
    logic [2:0]  button;
  } mcd_event_t;

  // Classification of one event.
  typedef struct packed {
    logic double_hit;
    logic triple_hit;
  } mcd_flags_t;

endpackage

// File: rtl/core/mcd_in_if.sv
// Input request channel of the multi-click detector: valid/ready plus event fields.
// Depends on mcd_pkg.
interface mcd_in_if;
  logic            valid;
  logic            ready;
  mcd_pkg::mcd_op_t op;
  logic [31:0]     timestamp;
  logic [15:0]     window_id;
  logic [2:0]      button;

  modport source (output valid, op, timestamp, window_id, button, input ready);
  modport sink   (input valid, op, timestamp, window_id, button, output ready);
endinterface

// File: rtl/core/mcd_out_if.sv
// Result request channel of the multi-click detector: valid/ready plus click flags.
// No dependencies.
interface mcd_out_if;
  logic valid;
  logic ready;
  logic double_hit;
  logic triple_hit;

  modport source (output valid, double_hit, triple_hit, input ready);
  modport sink   (input valid, double_hit, triple_hit, output ready);
endinterface

// File: rtl/core/mcd_history.sv
// Press history registers and click classification for one event.
// Depends on mcd_pkg. Flags are combinational from the event and the stored history.
module mcd_history #(
  parameter int TIME_BITS   = 32,
  parameter int WINDOW_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               ev_take,
  input  mcd_pkg::mcd_event_t ev,
  input  logic [15:0]        interval,
  output mcd_pkg::mcd_flags_t flags
);

  logic [TIME_BITS-1:0]   last_time_r,  last_time_nxt;
  logic [TIME_BITS-1:0]   prior_time_r, prior_time_nxt;
  logic [WINDOW_BITS-1:0] last_win_r,   last_win_nxt;
  logic [WINDOW_BITS-1:0] prior_win_r,  prior_win_nxt;
  logic                   triple_r,     triple_nxt;
  logic [1:0]             rel_cnt_r,    rel_cnt_nxt;

  logic [63:0]            ts_ext;
  logic [63:0]            win_ext;
  logic [TIME_BITS-1:0]   ts;
  logic [WINDOW_BITS-1:0] win;
  logic [TIME_BITS-1:0]   base_last_time, base_prior_time;
  logic [WINDOW_BITS-1:0] base_last_win, base_prior_win;
  logic [TIME_BITS-1:0]   diff_last, diff_prior;
  logic [16:0]            lim2;
  logic                   near_last, near_prior, win_last, win_prior;
  logic [1:0]             rel_inc;
  logic                   is_press, is_wheel;
  logic                   dbl, tpl;

  assign ts_ext  = 64'(ev.timestamp);
  assign win_ext = 64'(ev.window_id);
  assign ts      = ts_ext[TIME_BITS-1:0];
  assign win     = win_ext[WINDOW_BITS-1:0];

  assign is_press = (ev.op == mcd_pkg::OP_PRESS);
  assign is_wheel = (ev.button > mcd_pkg::BUTTON_MAX);

  // A press after a triple starts from a cleared history.
  always_comb begin
    if (is_press && triple_r) begin
      base_last_time  = '0;
      base_prior_time = '0;
      base_last_win   = '0;
      base_prior_win  = '0;
    end else begin
      base_last_time  = last_time_r;
      base_prior_time = prior_time_r;
      base_last_win   = last_win_r;
      base_prior_win  = prior_win_r;
    end
  end

  assign lim2       = {interval, 1'b0};
  assign diff_last  = ts - base_last_time;
  assign diff_prior = ts - base_prior_time;
  assign near_last  = 65'(diff_last) <= 65'(interval);
  assign near_prior = 65'(diff_prior) <= 65'(lim2);
  assign win_last   = (win == base_last_win);
  assign win_prior  = (win == base_prior_win);

  assign rel_inc = (rel_cnt_r == mcd_pkg::RELEASE_SAT) ? rel_cnt_r : rel_cnt_r + 2'd1;

  always_comb begin
    dbl            = 1'b0;
    tpl            = 1'b0;
    last_time_nxt  = last_time_r;
    prior_time_nxt = prior_time_r;
    last_win_nxt   = last_win_r;
    prior_win_nxt  = prior_win_r;
    triple_nxt     = triple_r;
    rel_cnt_nxt    = rel_cnt_r;
    if (is_press) begin
      if (!is_wheel) begin
        dbl            = near_last && win_last;
        tpl            = near_prior && win_last && win_prior;
        triple_nxt     = tpl;
        last_time_nxt  = base_last_time;
        prior_time_nxt = base_prior_time;
        last_win_nxt   = base_last_win;
        prior_win_nxt  = base_prior_win;
        if (!dbl && !tpl) begin
          rel_cnt_nxt = '0;
        end
        if (!tpl) begin
          prior_time_nxt = base_last_time;
          last_time_nxt  = ts;
          prior_win_nxt  = base_last_win;
          last_win_nxt   = win;
        end
      end
    end else begin
      rel_cnt_nxt = rel_inc;
      dbl = (rel_inc >= mcd_pkg::RELEASE_DOUBLE_MIN) && near_last && win_last;
      tpl = (rel_inc >= mcd_pkg::RELEASE_TRIPLE_MIN) && near_prior && win_last && win_prior;
    end
  end

  assign flags.double_hit = dbl;
  assign flags.triple_hit = tpl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r  <= '0;
      prior_time_r <= '0;
      last_win_r   <= '0;
      prior_win_r  <= '0;
      triple_r     <= 1'b0;
      rel_cnt_r    <= '0;
    end else if (ev_take) begin
      last_time_r  <= last_time_nxt;
      prior_time_r <= prior_time_nxt;
      last_win_r   <= last_win_nxt;
      prior_win_r  <= prior_win_nxt;
      triple_r     <= triple_nxt;
      rel_cnt_r    <= rel_cnt_nxt;
    end
  end

endmodule

// File: rtl/core/multi_click_detector.sv
// Multi-click detector top level: config register, history unit, result register.
// Depends on mcd_pkg, mcd_in_if, mcd_out_if and mcd_history.
// The result is registered and valid in the cycle after the request is accepted.
// Throughput: one request per cycle; ready while the result register is empty or draining.
// Reset (synchronous, rst_n low): history and counters cleared, interval back to 250 ms,
// no result pending.
module multi_click_detector #(
  parameter int TIME_BITS   = 32,
  parameter int WINDOW_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  mcd_in_if.sink           in_if,
  mcd_out_if.source        out_if,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_wdata
);

  // Double click interval in ms; triple window is twice this.
  logic [15:0] interval_r;

  logic                out_valid_r;
  mcd_pkg::mcd_flags_t flags_r;
  mcd_pkg::mcd_flags_t flags;
  mcd_pkg::mcd_event_t ev;
  logic                take;

  // Result register drains and refills in the same cycle, so a new request
  // is taken whenever the held result is gone or leaving.
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign take        = in_if.valid && in_if.ready;

  assign ev.op        = in_if.op;
  assign ev.timestamp = in_if.timestamp;
  assign ev.window_id = in_if.window_id;
  assign ev.button    = in_if.button;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= mcd_pkg::CFG_INTERVAL_RESET;
    end else if (cfg_we) begin
      interval_r <= cfg_wdata;
    end
  end

  // History state advances only on accepted requests; flags come out the same cycle.
  mcd_history #(
    .TIME_BITS   (TIME_BITS),
    .WINDOW_BITS (WINDOW_BITS)
  ) u_history (
    .clk      (clk),
    .rst_n    (rst_n),
    .ev_take  (take),
    .ev       (ev),
    .interval (interval_r),
    .flags    (flags)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (take) begin
      flags_r <= flags;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.double_hit = flags_r.double_hit;
  assign out_if.triple_hit = flags_r.triple_hit;

endmodule
